### design/tnfc_pkg.sv
// ----------------------------------------------------------------------------
// tnfc_pkg
// Shared constants, codes and types of the wrapping-map nearest free cell
// search block.
// ----------------------------------------------------------------------------
package tnfc_pkg;

  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int MAX_RADIUS = 31;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int SIZE_W     = 8;
  localparam int RAD_W      = 5;
  localparam int SIGN_W     = 2;
  localparam int D_W        = $clog2(MAX_RADIUS + 2);
  localparam int OFF_W      = D_W + 1;
  localparam int SQ_W       = 2 * D_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int MOD_W      = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int MCNT_W     = $clog2(MOD_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic signed [OFF_W-1:0] OFF_ONE = OFF_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_WB,
    ST_MOD,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } ctrl_state_e;

  typedef struct packed {
    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [MAX_COLS-1:0] wdata;
    logic                re;
    logic [ROW_W-1:0]    raddr;
  } ram_cmd_t;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } result_t;

endpackage

### design/tnfc_if.sv
// ----------------------------------------------------------------------------
// tnfc_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tnfc_req_if import tnfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [ROW_W-1:0]         cell_row;
  logic [COL_W-1:0]         cell_col;
  logic                     walkable;
  logic [RAD_W-1:0]         radius;
  logic signed [SIGN_W-1:0] row_sign;
  logic signed [SIGN_W-1:0] col_sign;

  modport source (
    output valid, req_type, cell_row, cell_col, walkable, radius, row_sign, col_sign,
    input  ready
  );
  modport sink (
    input  valid, req_type, cell_row, cell_col, walkable, radius, row_sign, col_sign,
    output ready
  );
endinterface

interface tnfc_rsp_if import tnfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [ROW_W-1:0] found_row;
  logic [COL_W-1:0] found_col;

  modport source (
    output valid, found, found_row, found_col,
    input  ready
  );
  modport sink (
    input  valid, found, found_row, found_col,
    output ready
  );
endinterface

### design/toroidal_nearest_free_cell_search.sv
// ----------------------------------------------------------------------------
// toroidal_nearest_free_cell_search
// Walkable map of a wrapping grid with nearest walkable cell search.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (valid/ready). A write request stores one map cell
// and produces no response: a row read, then a row write-back. A search
// request produces one response on rsp_o: found flag and cell. It first
// reduces the origin by the map size bit by bit, then visits the ring offsets
// in turn (sum of ring areas up to the hit, at most about 48k for radius 31
// with both signs zero), drains the last map read and loads the response
// register. The scan rate is set by the single map read port: one candidate
// read per cycle. Sizes are written on the cfg port (index 0 rows, 1 columns),
// values clamped to 1..128. The user must write them only while no request is
// in flight; the block does not enforce it. After reset the map is cleared to
// walls in a pass over all rows, one row per cycle; req_i.ready stays low
// until it ends. Config writes are taken anytime.
// The response sits in an output register; a new request is taken while it
// waits, but a following search holds its response until rsp_o drains.
// ----------------------------------------------------------------------------
module toroidal_nearest_free_cell_search import tnfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tnfc_req_if.sink              req_i,
  tnfc_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [SIZE_W-1:0]   rows_q, rows_d, cols_q, cols_d;
  logic [SIZE_W-1:0]   row_clamp, col_clamp;
  logic                rsp_valid_q, rsp_valid_d;
  result_t             rsp_q, rsp_d;
  logic                out_free;
  logic                res_valid;
  result_t             res;
  ram_cmd_t            ram_cmd;
  logic [MAX_COLS-1:0] ram_rdata;

  assign row_clamp = (cfg_wdata_i == '0) ? SIZE_W'(1) :
                     (cfg_wdata_i > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : cfg_wdata_i;
  assign col_clamp = (cfg_wdata_i == '0) ? SIZE_W'(1) :
                     (cfg_wdata_i > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cfg_wdata_i;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT: rows_d = row_clamp;
        CFG_COL_COUNT: cols_d = col_clamp;
        default: ;
      endcase
    end
  end

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (res_valid) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= SIZE_W'(MAX_ROWS);
      cols_q      <= SIZE_W'(MAX_COLS);
      rsp_valid_q <= 1'b0;
    end else begin
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.found     = rsp_q.found;
  assign rsp_o.found_row = rsp_q.row;
  assign rsp_o.found_col = rsp_q.col;

  tnfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .req_i       (req_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_cmd_o   (ram_cmd),
    .ram_rdata_i (ram_rdata)
  );

  tnfc_map_ram u_map_ram (
    .clk_i   (clk_i),
    .cmd_i   (ram_cmd),
    .rdata_o (ram_rdata)
  );

endmodule

### design/tnfc_map_ram.sv
// ----------------------------------------------------------------------------
// tnfc_map_ram
// Walkable map storage: one row per entry, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module tnfc_map_ram import tnfc_pkg::*; (
  input  logic                clk_i,
  input  ram_cmd_t            cmd_i,
  output logic [MAX_COLS-1:0] rdata_o
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tnfc_ctrl.sv
// ----------------------------------------------------------------------------
// tnfc_ctrl
// Sequencer: clearing pass, read-modify-write of map rows, origin reduction
// and the ring scan with one map read per qualifying offset.
// ----------------------------------------------------------------------------
module tnfc_ctrl import tnfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIZE_W-1:0]   rows_i,
  input  logic [SIZE_W-1:0]   cols_i,
  tnfc_req_if.sink            req_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output result_t             res_o,
  output ram_cmd_t            ram_cmd_o,
  input  logic [MAX_COLS-1:0] ram_rdata_i
);

  ctrl_state_e state_q, state_d;

  logic [ROW_W-1:0]        clr_q, clr_d;
  logic [ROW_W-1:0]        wr_row_q, wr_row_d;
  logic [COL_W-1:0]        wr_col_q, wr_col_d;
  logic                    wr_val_q, wr_val_d;
  logic [MOD_W-1:0]        org_row_q, org_row_d;
  logic [MOD_W-1:0]        org_col_q, org_col_d;
  logic [ROW_W-1:0]        rem_row_q, rem_row_d;
  logic [COL_W-1:0]        rem_col_q, rem_col_d;
  logic [MCNT_W-1:0]       mod_cnt_q, mod_cnt_d;
  logic [RAD_W-1:0]        rad_q, rad_d;
  logic [SQ_W-1:0]         rad_sq_q, rad_sq_d;
  logic                    rneg_q, rneg_d, rpos_q, rpos_d;
  logic                    cneg_q, cneg_d, cpos_q, cpos_d;
  logic [D_W-1:0]          d_q, d_d;
  logic signed [OFF_W-1:0] dr_q, dr_d, dc_q, dc_d;
  logic [ROW_W-1:0]        rstart_q, rstart_d, rcur_q, rcur_d;
  logic [COL_W-1:0]        cstart_q, cstart_d, ccur_q, ccur_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [ROW_W-1:0]        pend_row_q, pend_row_d;
  logic [COL_W-1:0]        pend_col_q, pend_col_d;
  result_t                 res_q, res_d;

  logic                    accept;
  logic                    wr_in_map;
  logic [SIZE_W-1:0]       t_row, t_col;
  logic signed [OFF_W-1:0] d_ext, d_nxt_ext, dr_hi, dc_hi, dr_abs, dc_abs;
  logic [D_W-1:0]          dr_mag, dc_mag;
  logic [SUM_W-1:0]        dist_sq;
  logic                    qualify, row_end, col_end, ring_end, last, hit;
  logic [ROW_W-1:0]        rstart_nxt;
  logic [COL_W-1:0]        cstart_nxt;
  logic [MAX_COLS-1:0]     wb_row;

  function automatic logic [ROW_W-1:0] dec_row(input logic [ROW_W-1:0] x,
                                               input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    m = n - SIZE_W'(1);
    return (x == '0) ? m[ROW_W-1:0] : x - ROW_W'(1);
  endfunction

  function automatic logic [COL_W-1:0] dec_col(input logic [COL_W-1:0] x,
                                               input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    m = n - SIZE_W'(1);
    return (x == '0) ? m[COL_W-1:0] : x - COL_W'(1);
  endfunction

  function automatic logic [ROW_W-1:0] inc_row(input logic [ROW_W-1:0] x,
                                               input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] p;
    p = SIZE_W'(x) + SIZE_W'(1);
    return (p == n) ? '0 : p[ROW_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] inc_col(input logic [COL_W-1:0] x,
                                               input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] p;
    p = SIZE_W'(x) + SIZE_W'(1);
    return (p == n) ? '0 : p[COL_W-1:0];
  endfunction

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign wr_in_map   = (SIZE_W'(req_i.cell_row) < rows_i) && (SIZE_W'(req_i.cell_col) < cols_i);

  // restoring remainder step, one dividend bit per cycle
  assign t_row = SIZE_W'({rem_row_q, org_row_q[MOD_W-1]});
  assign t_col = SIZE_W'({rem_col_q, org_col_q[MOD_W-1]});

  // offset qualification and loop bounds
  assign d_ext     = $signed({1'b0, d_q});
  assign d_nxt_ext = d_ext + OFF_ONE;
  assign dr_hi     = rpos_q ? d_ext : '0;
  assign dc_hi     = cpos_q ? d_ext : '0;
  assign dr_abs    = dr_q[OFF_W-1] ? -dr_q : dr_q;
  assign dc_abs    = dc_q[OFF_W-1] ? -dc_q : dc_q;
  assign dr_mag    = dr_abs[D_W-1:0];
  assign dc_mag    = dc_abs[D_W-1:0];
  assign dist_sq   = SUM_W'(dr_mag) * SUM_W'(dr_mag) + SUM_W'(dc_mag) * SUM_W'(dc_mag);
  assign qualify   = dist_sq < SUM_W'(rad_sq_q);
  assign row_end   = (dr_q == dr_hi);
  assign col_end   = (dc_q == dc_hi);
  assign ring_end  = (d_q == D_W'(rad_q) + D_W'(1));
  assign last      = row_end && col_end && ring_end;
  assign hit       = pend_valid_q && ram_rdata_i[pend_col_q];

  assign rstart_nxt = rneg_q ? dec_row(rstart_q, rows_i) : rstart_q;
  assign cstart_nxt = cneg_q ? dec_col(cstart_q, cols_i) : cstart_q;

  always_comb begin
    wb_row           = ram_rdata_i;
    wb_row[wr_col_q] = wr_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_row_q   <= wr_row_d;
    wr_col_q   <= wr_col_d;
    wr_val_q   <= wr_val_d;
    org_row_q  <= org_row_d;
    org_col_q  <= org_col_d;
    rem_row_q  <= rem_row_d;
    rem_col_q  <= rem_col_d;
    mod_cnt_q  <= mod_cnt_d;
    rad_q      <= rad_d;
    rad_sq_q   <= rad_sq_d;
    rneg_q     <= rneg_d;
    rpos_q     <= rpos_d;
    cneg_q     <= cneg_d;
    cpos_q     <= cpos_d;
    d_q        <= d_d;
    dr_q       <= dr_d;
    dc_q       <= dc_d;
    rstart_q   <= rstart_d;
    cstart_q   <= cstart_d;
    rcur_q     <= rcur_d;
    ccur_q     <= ccur_d;
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    wr_row_d     = wr_row_q;
    wr_col_d     = wr_col_q;
    wr_val_d     = wr_val_q;
    org_row_d    = org_row_q;
    org_col_d    = org_col_q;
    rem_row_d    = rem_row_q;
    rem_col_d    = rem_col_q;
    mod_cnt_d    = mod_cnt_q;
    rad_d        = rad_q;
    rad_sq_d     = rad_sq_q;
    rneg_d       = rneg_q;
    rpos_d       = rpos_q;
    cneg_d       = cneg_q;
    cpos_d       = cpos_q;
    d_d          = d_q;
    dr_d         = dr_q;
    dc_d         = dc_q;
    rstart_d     = rstart_q;
    cstart_d     = cstart_q;
    rcur_d       = rcur_q;
    ccur_d       = ccur_q;
    pend_valid_d = 1'b0;
    pend_row_d   = pend_row_q;
    pend_col_d   = pend_col_q;
    res_d        = res_q;
    res_valid_o  = 1'b0;
    ram_cmd_o    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_cmd_o.we    = 1'b1;
        ram_cmd_o.waddr = clr_q;
        clr_d           = clr_q + ROW_W'(1);
        if (clr_q == ROW_W'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_cmd_o.re    = accept;
        ram_cmd_o.raddr = req_i.cell_row;
        if (accept) begin
          wr_row_d  = req_i.cell_row;
          wr_col_d  = req_i.cell_col;
          wr_val_d  = req_i.walkable;
          org_row_d = MOD_W'(req_i.cell_row);
          org_col_d = MOD_W'(req_i.cell_col);
          rem_row_d = '0;
          rem_col_d = '0;
          mod_cnt_d = '0;
          rad_d     = req_i.radius;
          rad_sq_d  = SQ_W'(req_i.radius) * SQ_W'(req_i.radius);
          rneg_d    = (req_i.row_sign != SIGN_W'(1));
          rpos_d    = !req_i.row_sign[SIGN_W-1];
          cneg_d    = (req_i.col_sign != SIGN_W'(1));
          cpos_d    = !req_i.col_sign[SIGN_W-1];
          if (req_i.req_type == REQ_SEARCH) begin
            state_d = ST_MOD;
          end else if (wr_in_map) begin
            state_d = ST_WR_WB;
          end
        end
      end

      ST_WR_WB: begin
        ram_cmd_o.we    = 1'b1;
        ram_cmd_o.waddr = wr_row_q;
        ram_cmd_o.wdata = wb_row;
        state_d         = ST_IDLE;
      end

      ST_MOD: begin
        org_row_d = org_row_q << 1;
        org_col_d = org_col_q << 1;
        rem_row_d = (t_row >= rows_i) ? ROW_W'(t_row - rows_i) : t_row[ROW_W-1:0];
        rem_col_d = (t_col >= cols_i) ? COL_W'(t_col - cols_i) : t_col[COL_W-1:0];
        mod_cnt_d = mod_cnt_q + MCNT_W'(1);
        if (mod_cnt_q == MCNT_W'(MOD_W - 1)) begin
          rstart_d = rneg_q ? dec_row(rem_row_d, rows_i) : rem_row_d;
          cstart_d = cneg_q ? dec_col(rem_col_d, cols_i) : rem_col_d;
          rcur_d   = rstart_d;
          ccur_d   = cstart_d;
          d_d      = D_W'(1);
          dr_d     = rneg_q ? -OFF_ONE : '0;
          dc_d     = cneg_q ? -OFF_ONE : '0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        ram_cmd_o.re    = qualify;
        ram_cmd_o.raddr = rcur_q;
        if (hit) begin
          res_d   = '{found: 1'b1, row: pend_row_q, col: pend_col_q};
          state_d = ST_FLUSH;
        end else begin
          pend_valid_d = qualify;
          pend_row_d   = rcur_q;
          pend_col_d   = ccur_q;
          if (last) begin
            state_d = ST_DRAIN;
          end else if (!col_end) begin
            dc_d   = dc_q + OFF_ONE;
            ccur_d = inc_col(ccur_q, cols_i);
          end else if (!row_end) begin
            dc_d   = cneg_q ? -d_ext : '0;
            ccur_d = cstart_q;
            dr_d   = dr_q + OFF_ONE;
            rcur_d = inc_row(rcur_q, rows_i);
          end else begin
            d_d      = d_q + D_W'(1);
            rstart_d = rstart_nxt;
            cstart_d = cstart_nxt;
            rcur_d   = rstart_nxt;
            ccur_d   = cstart_nxt;
            dr_d     = rneg_q ? -d_nxt_ext : '0;
            dc_d     = cneg_q ? -d_nxt_ext : '0;
          end
        end
      end

      ST_DRAIN: begin
        if (hit) begin
          res_d = '{found: 1'b1, row: pend_row_q, col: pend_col_q};
        end else begin
          res_d = '0;
        end
        state_d = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign res_o = res_q;

`ifndef SYNTH
  a_we_only_clear_or_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_cmd_o.we |-> (state_q == ST_CLEAR || state_q == ST_WR_WB))
    else $error("map write outside clear or write-back");

  a_write_goes_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == REQ_WRITE && wr_in_map) |=> (state_q == ST_WR_WB))
    else $error("in-map write request did not reach write-back");

  a_scan_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((SIZE_W'(rcur_q) < rows_i) && (SIZE_W'(ccur_q) < cols_i)))
    else $error("scan position outside map");

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (d_q <= D_W'(rad_q) + D_W'(1)))
    else $error("ring beyond radius");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == ST_IDLE))
    else $error("result issued without return to idle");
`endif

endmodule

### bench/tnfc_search_checker.sv
// ----------------------------------------------------------------------------
// tnfc_search_checker
// Watches the size writes, the request channel and the response channel of
// the wrapping-map nearest free cell search. Keeps its own walkable map and
// sizes, works out the answer of every accepted search and compares each
// response, field by field, with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module tnfc_search_checker import tnfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tnfc_req_if                   req_i,
  tnfc_rsp_if                   rsp_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  logic            walk_map [MAX_ROWS][MAX_COLS];
  logic [SIZE_W-1:0] row_count_q;
  logic [SIZE_W-1:0] col_count_q;
  result_t         expected_hits [$];
  result_t         predicted;
  result_t         want;
  int              mismatch_cnt;
  int              map_rows;
  int              map_cols;

  function automatic int clamp_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int wrap_index(input int v, input int n);
    int m;
    m = v % n;
    if (m < 0) m += n;
    return m;
  endfunction

  function automatic result_t nearest_walkable(input int orow, input int ocol, input int rad_in,
                                               input logic [1:0] rsign, input logic [1:0] csign);
    int      rows, cols, rad;
    int      rmin, rmax, cmin, cmax;
    int      d, dr, dc, r, c;
    result_t res;
    rows = clamp_size(int'(row_count_q), MAX_ROWS);
    cols = clamp_size(int'(col_count_q), MAX_COLS);
    rad  = (rad_in > MAX_RADIUS) ? MAX_RADIUS : rad_in;
    rmin = -1; rmax = 1; cmin = -1; cmax = 1;
    res  = '0;
    if (rsign == 2'b01) rmin = 0;
    else if (rsign[1]) rmax = 0;
    if (csign == 2'b01) cmin = 0;
    else if (csign[1]) cmax = 0;
    for (d = 1; d <= rad + 1; d++) begin
      for (dr = d * rmin; dr <= d * rmax; dr++) begin
        for (dc = d * cmin; dc <= d * cmax; dc++) begin
          if (dr * dr + dc * dc < rad * rad) begin
            r = wrap_index(orow + dr, rows);
            c = wrap_index(ocol + dc, cols);
            if (walk_map[r][c]) begin
              res.found = 1'b1;
              res.row   = ROW_W'(r);
              res.col   = COL_W'(c);
              return res;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (walk_map[r, c]) walk_map[r][c] = 1'b0;
      row_count_q  = SIZE_W'(MAX_ROWS);
      col_count_q  = SIZE_W'(MAX_COLS);
      expected_hits.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROW_COUNT: row_count_q = cfg_wdata_i;
          CFG_COL_COUNT: col_count_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_WRITE) begin
          map_rows = clamp_size(int'(row_count_q), MAX_ROWS);
          map_cols = clamp_size(int'(col_count_q), MAX_COLS);
          if (int'(req_i.cell_row) < map_rows && int'(req_i.cell_col) < map_cols)
            walk_map[req_i.cell_row][req_i.cell_col] = req_i.walkable;
        end else begin
          predicted = nearest_walkable(int'(req_i.cell_row), int'(req_i.cell_col),
                                       int'(req_i.radius), req_i.row_sign, req_i.col_sign);
          expected_hits = {expected_hits, predicted};
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: response with none expected: found=%0d row=%0d col=%0d", $time,
                   rsp_i.found, rsp_i.found_row, rsp_i.found_col);
          mismatch_cnt++;
        end else begin
          want = expected_hits.pop_front();
          if (rsp_i.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_i.found);
            mismatch_cnt++;
          end
          if (rsp_i.found_row !== want.row) begin
            $display("%0t: found_row expected %0d actual %0d", $time, want.row,
                     rsp_i.found_row);
            mismatch_cnt++;
          end
          if (rsp_i.found_col !== want.col) begin
            $display("%0t: found_col expected %0d actual %0d", $time, want.col,
                     rsp_i.found_col);
            mismatch_cnt++;
          end
        end
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= expected_hits.size();
    end
  end

endmodule

### bench/toroidal_nearest_free_cell_search_test.sv
// ----------------------------------------------------------------------------
// toroidal_nearest_free_cell_search_test
// Drives cell writes and nearest walkable cell searches over a range of map
// sizes, starting with hand-picked corner cases and going on with random
// requests in bursts, while the response side stalls at random. The checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module toroidal_nearest_free_cell_search_test;
  import tnfc_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  localparam logic [1:0] SIGN_BOTH = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG2 = 2'b10;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    mismatches;
  int                    pending;
  int                    burst_left;
  int                    holds_asked;
  int                    holds_done;
  int                    eff_rows;
  int                    eff_cols;

  tnfc_req_if req_if ();
  tnfc_rsp_if rsp_if ();

  toroidal_nearest_free_cell_search i_dut (
    .clk_i,
    .rst_ni,
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  tnfc_search_checker i_checker (
    .clk_i,
    .rst_ni,
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("toroidal_nearest_free_cell_search_test failed");
    $finish;
  end

  // response side: random stall pattern, plus long hold-offs on demand
  initial begin
    int       seg_len;
    rx_mode_e mode;
    rsp_if.ready = 1'b0;
    forever begin
      seg_len = $urandom_range(1, 40);
      mode    = rx_mode_e'($urandom_range(0, 2));
      repeat (seg_len) begin
        @(negedge clk_i);
        if (holds_done != holds_asked) begin
          rsp_if.ready = 1'b0;
          repeat (300) @(negedge clk_i);
          holds_done++;
        end
        case (mode)
          RX_OPEN: rsp_if.ready = 1'b1;
          RX_COIN: rsp_if.ready = 1'($urandom_range(0, 1));
          default: rsp_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_request(input req_type_e kind, input int row, input int col,
                              input int walk, input int rad, input logic [1:0] rsign,
                              input logic [1:0] csign);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.req_type = kind;
    req_if.cell_row = ROW_W'(row);
    req_if.cell_col = COL_W'(col);
    req_if.walkable = 1'(walk);
    req_if.radius   = RAD_W'(rad);
    req_if.row_sign = rsign;
    req_if.col_sign = csign;
    req_if.valid    = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic write_cell(input int row, input int col, input int walk);
    send_request(REQ_WRITE, row, col, walk, $urandom_range(0, 31), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)));
  endtask

  task automatic search(input int row, input int col, input int rad, input logic [1:0] rsign,
                        input logic [1:0] csign);
    send_request(REQ_SEARCH, row, col, $urandom_range(0, 1), rad, rsign, csign);
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    burst_left   = 0;
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_size(input int rows, input int cols);
    wait_for_idle();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_ROW_COUNT;
    cfg_wdata_i = CFG_DATA_W'(rows);
    @(negedge clk_i);
    cfg_idx_i   = CFG_COL_COUNT;
    cfg_wdata_i = CFG_DATA_W'(cols);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    eff_rows = (rows < 1) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
    eff_cols = (cols < 1) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
  endtask

  function automatic int pick_size();
    int extremes [4] = '{0, 1, 128, 255};
    if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 3)];
    return $urandom_range(2, 20);
  endfunction

  function automatic int pick_radius();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 88) return $urandom_range(0, 6);
    if (pick < 98) return $urandom_range(7, 15);
    return $urandom_range(16, 31);
  endfunction

  initial begin
    int rows_tab [4] = '{0, 1, 128, 255};
    int cols_tab [4] = '{255, 1, 128, 0};
    int phase_items;
    int row, col;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_WRITE;
    req_if.cell_row = '0;
    req_if.cell_col = '0;
    req_if.walkable = 1'b0;
    req_if.radius   = '0;
    req_if.row_sign = '0;
    req_if.col_sign = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ROW_COUNT;
    cfg_wdata_i     = '0;
    burst_left      = 0;
    holds_asked     = 0;
    holds_done      = 0;
    eff_rows        = MAX_ROWS;
    eff_cols        = MAX_COLS;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty map, wrap at both edges, all sign codes
    search(0, 0, 0, SIGN_BOTH, SIGN_BOTH);
    search(127, 127, 31, SIGN_BOTH, SIGN_BOTH);
    write_cell(127, 127, 1);
    write_cell(0, 0, 1);
    search(0, 0, 1, SIGN_BOTH, SIGN_BOTH);
    search(0, 0, 2, SIGN_NEG, SIGN_NEG);
    search(0, 0, 2, SIGN_NEG2, SIGN_NEG2);
    write_cell(0, 0, 0);
    search(126, 126, 3, SIGN_POS, SIGN_POS);
    // small map: writes outside ignored, origin wraps, radius beyond map
    set_size(8, 8);
    write_cell(10, 3, 1);
    write_cell(3, 10, 1);
    write_cell(7, 7, 1);
    search(64, 64, 2, SIGN_BOTH, SIGN_BOTH);
    search(3, 3, 20, SIGN_BOTH, SIGN_BOTH);
    // sizes clamped at both ends
    set_size(0, 255);
    search(5, 5, 4, SIGN_BOTH, SIGN_POS);
    set_size(255, 0);
    write_cell(127, 0, 1);
    write_cell(127, 5, 1);
    search(0, 0, 2, SIGN_NEG, SIGN_BOTH);
    // resize keeps the map
    set_size(128, 128);
    search(10, 3, 1, SIGN_BOTH, SIGN_BOTH);
    search(3, 10, 1, SIGN_BOTH, SIGN_BOTH);
    set_size(1, 1);
    write_cell(0, 0, 1);
    search(90, 45, 31, SIGN_BOTH, SIGN_BOTH);

    // random phases over several map sizes
    for (int p = 0; p < 10; p++) begin
      if (p < 4) set_size(rows_tab[p], cols_tab[p]);
      else set_size(pick_size(), pick_size());
      if (p == 2 || p == 6) begin
        holds_asked++;
        repeat (8) search($urandom_range(0, eff_rows - 1), $urandom_range(0, eff_cols - 1),
                          $urandom_range(0, 1), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)));
        wait_for_idle();
      end
      phase_items = 0;
      while (phase_items < 50) begin
        if ($urandom_range(0, 49) == 0) wait_for_idle();
        if ($urandom_range(0, 1) == 0) begin
          row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, eff_rows - 1);
          col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, eff_cols - 1);
          write_cell(row, col, ($urandom_range(0, 9) < 4));
          if (row < eff_rows && col < eff_cols) phase_items++;
        end else begin
          row = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, eff_rows - 1);
          col = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, eff_cols - 1);
          search(row, col, pick_radius(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
          phase_items++;
        end
      end
    end

    wait_for_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("toroidal_nearest_free_cell_search_test passed");
    end else begin
      $display("toroidal_nearest_free_cell_search_test failed");
    end
    $finish;
  end

endmodule

### toroidal_nearest_free_cell_search.f
design/tnfc_pkg.sv
design/tnfc_if.sv
design/tnfc_map_ram.sv
design/tnfc_ctrl.sv
design/toroidal_nearest_free_cell_search.sv
bench/tnfc_search_checker.sv
bench/toroidal_nearest_free_cell_search_test.sv
